@@ rtl/core/bpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants and arithmetic helpers for the pressure compensation core.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned DIV_W = 32;
  localparam int unsigned LAT = 78;

  localparam logic [1:0] REG_CAL0 = 2'd0;
  localparam logic [1:0] REG_CAL1 = 2'd1;
  localparam logic [1:0] REG_CAL2 = 2'd2;
  localparam logic [1:0] REG_OSS  = 2'd3;

  localparam logic signed [10:0] TEMP_MIN = -11'sd400;
  localparam logic signed [10:0] TEMP_MAX = 11'sd850;
  localparam logic [16:0] PRESS_MAX = 17'h1FFFF;

  // Signed division by 2^k, rounding toward zero.
  function automatic logic signed [31:0] tdiv(input logic signed [31:0] v,
                                               input int unsigned k);
    logic signed [31:0] bias;
    logic [63:0] mask;
    mask = (64'd1 << k) - 64'd1;
    bias = v[31] ? $signed(mask[31:0]) : 32'sd0;
    return (v + bias) >>> k;
  endfunction

  // Low 32 bits of a signed product.
  function automatic logic signed [31:0] mul_lo(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] m;
    m = a * b;
    return m[31:0];
  endfunction

endpackage

@@ rtl/core/bpc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module bpc_div
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W-1:0] rem_r [DIV_W];
  logic [DIV_W-1:0] nq_r  [DIV_W];
  logic [DIV_W-1:0] d_r   [DIV_W];

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic [DIV_W-1:0] rin, nin, din;
    logic [DIV_W:0]   sh;
    logic             ge;
    logic [DIV_W-1:0] rem_nxt, nq_nxt;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign nin = num;
      assign din = den;
    end else begin : g_rest
      assign rin = rem_r[i-1];
      assign nin = nq_r[i-1];
      assign din = d_r[i-1];
    end

    always_comb begin
      sh = {rin, nin[DIV_W-1]};
      ge = (sh >= {1'b0, din});
      rem_nxt = ge ? DIV_W'(sh - {1'b0, din}) : sh[DIV_W-1:0];
      nq_nxt = {nin[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        nq_r[i] <= nq_nxt;
        d_r[i] <= din;
      end
    end
  end

  assign quo = nq_r[DIV_W-1];

endmodule

@@ rtl/core/barometric_pressure_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation with calibration registers.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata: raw_temp[15:0], raw_press[39:16]
//  out_    | master    | tdata: temp_tenths[10:0], press_pa[27:11]; tuser: div_error
//  cfg_    | write     | register index and data, no read-back
//
// One beat is accepted per cycle while the output is not stalled; each result
// passes 78 register stages before it is valid at the outputs. The stages
// are set by the two 32-stage dividers and the multiply stages around them.
// The whole pipeline holds while a result waits and out_tready is low.
// Reset clears the valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temp[15:0], raw_press[39:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // temp_tenths[10:0], press_pa[27:11], zero
  output logic        out_tuser,  // div_error[0]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef struct packed {
    logic [15:0]        ut;
    logic [23:0]        up;
    logic signed [31:0] p1, x1t, den;
    logic               dz, qneg;
    logic signed [10:0] temp;
    logic signed [31:0] b6, sq, ac2b6, ac3b6, x1a, x1c, b2sq, b1sq, b3, x3p;
    logic [31:0]        b4p, diff, b4, b7;
    logic               b4z;
    logic signed [31:0] p, pd, x1, x2, x1b;
    logic [16:0]        press;
    logic               err;
  } ctx_t;

  logic [63:0] cal0_r, cal1_r;
  logic [47:0] cal2_r;
  logic [1:0]  oss_r;
  logic [LAT-1:0] vld_r;
  logic adv;

  ctx_t st_r [14];
  ctx_t st_nxt [14];
  ctx_t line1_r [DIV_W];
  ctx_t line2_r [DIV_W];

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
  logic [DIV_W-1:0] d1_num, d1_den, d1_q, d2_num, d2_den, d2_q;

  assign ac1 = 32'(signed'(cal0_r[15:0]));
  assign ac2 = 32'(signed'(cal0_r[31:16]));
  assign ac3 = 32'(signed'(cal0_r[47:32]));
  assign ac4 = $signed({16'd0, cal0_r[63:48]});
  assign ac5 = $signed({16'd0, cal1_r[15:0]});
  assign ac6 = $signed({16'd0, cal1_r[31:16]});
  assign b1  = 32'(signed'(cal1_r[47:32]));
  assign b2  = 32'(signed'(cal1_r[63:48]));
  assign mc  = 32'(signed'(cal2_r[31:16]));
  assign md  = 32'(signed'(cal2_r[47:32]));

  assign adv = !vld_r[LAT-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r <= '0;
      cal1_r <= '0;
      cal2_r <= '0;
      oss_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAL0: cal0_r <= cfg_data;
        REG_CAL1: cal1_r <= cfg_data;
        REG_CAL2: cal2_r <= cfg_data[47:0];
        REG_OSS:  oss_r <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_comb begin
    logic signed [16:0] dt;
    logic signed [33:0] m34;
    logic signed [31:0] t, b5, x3, sum;
    logic [31:0] q;
    logic [15:0] kmul;
    logic [23:0] rp;

    rp = in_tdata[39:16];
    st_nxt[0] = st_r[0];
    st_nxt[0].ut = in_tdata[15:0];
    st_nxt[0].up = rp >> (4'd8 - {2'b00, oss_r});

    st_nxt[1] = st_r[0];
    dt = $signed({1'b0, st_r[0].ut}) - $signed({1'b0, cal1_r[31:16]});
    m34 = dt * $signed({1'b0, cal1_r[15:0]});
    st_nxt[1].p1 = m34[31:0];

    st_nxt[2] = st_r[1];
    st_nxt[2].x1t = tdiv(st_r[1].p1, 15);
    st_nxt[2].den = tdiv(st_r[1].p1, 15) + md;
    st_nxt[2].dz = ((tdiv(st_r[1].p1, 15) + md) == 32'sd0);
    st_nxt[2].qneg = mc[31] ^ st_nxt[2].den[31];

    st_nxt[3] = line1_r[DIV_W-1];
    q = line1_r[DIV_W-1].qneg ? -d1_q : d1_q;
    b5 = line1_r[DIV_W-1].x1t + $signed(q);
    t = tdiv(b5 + 32'sd8, 4);
    if (t < 32'(TEMP_MIN)) st_nxt[3].temp = TEMP_MIN;
    else if (t > 32'(TEMP_MAX)) st_nxt[3].temp = TEMP_MAX;
    else st_nxt[3].temp = t[10:0];
    st_nxt[3].b6 = b5 - 32'sd4000;

    st_nxt[4] = st_r[3];
    st_nxt[4].sq = mul_lo(st_r[3].b6, st_r[3].b6);
    st_nxt[4].ac2b6 = mul_lo(ac2, st_r[3].b6);
    st_nxt[4].ac3b6 = mul_lo(ac3, st_r[3].b6);

    st_nxt[5] = st_r[4];
    st_nxt[5].sq = tdiv(st_r[4].sq, 12);
    st_nxt[5].x1a = tdiv(st_r[4].ac2b6, 11);
    st_nxt[5].x1c = tdiv(st_r[4].ac3b6, 13);

    st_nxt[6] = st_r[5];
    st_nxt[6].b2sq = mul_lo(b2, st_r[5].sq);
    st_nxt[6].b1sq = mul_lo(b1, st_r[5].sq);

    st_nxt[7] = st_r[6];
    x3 = tdiv(st_r[6].b2sq, 11) + st_r[6].x1a;
    st_nxt[7].b3 = tdiv((((ac1 <<< 2) + x3) <<< oss_r) + 32'sd2, 2);
    sum = st_r[6].x1c + tdiv(st_r[6].b1sq, 16) + 32'sd2;
    st_nxt[7].x3p = tdiv(sum, 2) + 32'sd32768;

    st_nxt[8] = st_r[7];
    st_nxt[8].b4p = mul_lo(ac4, st_r[7].x3p);
    st_nxt[8].diff = 32'({8'd0, st_r[7].up}) - st_r[7].b3;

    st_nxt[9] = st_r[8];
    kmul = 16'd50000 >> oss_r;
    st_nxt[9].b4 = st_r[8].b4p >> 15;
    st_nxt[9].b4z = ((st_r[8].b4p >> 15) == 32'd0);
    st_nxt[9].b7 = mul_lo(st_r[8].diff, $signed({16'd0, kmul}));

    st_nxt[10] = line2_r[DIV_W-1];
    st_nxt[10].p = line2_r[DIV_W-1].b7[31] ? $signed(d2_q << 1) : $signed(d2_q);
    st_nxt[10].pd = tdiv(st_nxt[10].p, 8);

    st_nxt[11] = st_r[10];
    st_nxt[11].x1 = mul_lo(st_r[10].pd, st_r[10].pd);
    st_nxt[11].x2 = tdiv(mul_lo(-32'sd7357, st_r[10].p), 16);

    st_nxt[12] = st_r[11];
    st_nxt[12].x1b = tdiv(mul_lo(st_r[11].x1, 32'sd3038), 16);

    st_nxt[13] = st_r[12];
    sum = st_r[12].p + tdiv(st_r[12].x1b + st_r[12].x2 + 32'sd3791, 4);
    if (sum < 32'sd0) st_nxt[13].press = '0;
    else if (sum > 32'(PRESS_MAX)) st_nxt[13].press = PRESS_MAX;
    else st_nxt[13].press = sum[16:0];
    st_nxt[13].err = 1'b0;
    if (st_r[12].dz) begin
      st_nxt[13].temp = TEMP_MAX;
      st_nxt[13].press = PRESS_MAX;
      st_nxt[13].err = 1'b1;
    end else if (st_r[12].b4z) begin
      st_nxt[13].press = PRESS_MAX;
      st_nxt[13].err = 1'b1;
    end
  end

  assign d1_num = mc[31] ? DIV_W'(-(mc <<< 11)) : DIV_W'(mc <<< 11);
  assign d1_den = st_r[2].den[31] ? DIV_W'(-st_r[2].den) : DIV_W'(st_r[2].den);
  assign d2_num = st_r[9].b7[31] ? st_r[9].b7 : (st_r[9].b7 << 1);
  assign d2_den = st_r[9].b4;

  bpc_div u_div_temp (
    .clk(clk), .en(adv), .num(d1_num), .den(d1_den), .quo(d1_q)
  );

  bpc_div u_div_press (
    .clk(clk), .en(adv), .num(d2_num), .den(d2_den), .quo(d2_q)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 14; i++) begin
        st_r[i] <= st_nxt[i];
      end
      line1_r[0] <= st_r[2];
      line2_r[0] <= st_r[9];
      for (int i = 1; i < DIV_W; i++) begin
        line1_r[i] <= line1_r[i-1];
        line2_r[i] <= line2_r[i-1];
      end
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata = {4'd0, st_r[13].press, st_r[13].temp};
  assign out_tuser = st_r[13].err;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid) else $error("input held without a waiting result");
  a_err_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[27:11] == PRESS_MAX))
    else $error("error beat without saturated pressure");
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[10:0]) >= TEMP_MIN &&
                    $signed(out_tdata[10:0]) <= TEMP_MAX))
    else $error("temperature out of range");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the barometric pressure compensation core. Raw
// temperature and pressure beats are driven with random gaps, each result is
// compared field by field with an in-bench model of the integer scheme, and
// several calibration sets and every oversampling mode are exercised.
// ----------------------------------------------------------------------------
module tb
  import bpc_pkg::*;
();

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [10:0] temp_tenths;
    logic [16:0]        press_pa;
    logic               div_error;
  } comp_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  logic [63:0] cal0, cal1, cal2;
  logic [1:0]  oss;
  comp_result_t pending_results[$];
  int errors;
  bit sink_stall_en;

  barometric_pressure_compensation u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("barometric_pressure_compensation test failed");
    $finish;
  end

  function automatic longint w32(longint x);
    return longint'(int'(x[31:0]));
  endfunction

  function automatic longint sw(logic [63:0] r, int pos);
    logic [15:0] u;
    u = r[pos +: 16];
    return longint'($signed(u));
  endfunction

  function automatic longint uw(logic [63:0] r, int pos);
    logic [15:0] u;
    u = r[pos +: 16];
    return longint'({48'd0, u});
  endfunction

  function automatic comp_result_t compensate(logic [15:0] raw_t, logic [23:0] raw_p);
    comp_result_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b3, b5, b6, t, p, den, sq;
    u64_t b4, b7, pu;
    ac1 = sw(cal0, 0); ac2 = sw(cal0, 16); ac3 = sw(cal0, 32); ac4 = uw(cal0, 48);
    ac5 = uw(cal1, 0); ac6 = uw(cal1, 16); b1 = sw(cal1, 32); b2 = sw(cal1, 48);
    mc = sw(cal2, 16); md = sw(cal2, 32);
    ut = longint'({48'd0, raw_t});
    up = longint'({40'd0, raw_p} >> (8 - oss));
    r.div_error = 1'b0;
    x1 = w32(w32((ut - ac6) * ac5) / 32768);
    den = w32(x1 + md);
    if (den == 0) begin
      r.temp_tenths = 11'sd850;
      r.press_pa = 17'h1FFFF;
      r.div_error = 1'b1;
      return r;
    end
    x2 = w32(w32(mc * 2048) / den);
    b5 = w32(x1 + x2);
    t = w32(b5 + 8) / 16;
    if (t < -400) t = -400;
    else if (t > 850) t = 850;
    r.temp_tenths = t[10:0];
    b6 = w32(b5 - 4000);
    sq = w32(b6 * b6) / 4096;
    x1 = w32(b2 * sq) / 2048;
    x2 = w32(ac2 * b6) / 2048;
    x3 = w32(x1 + x2);
    b3 = w32(w32(w32(w32(ac1 * 4) + x3) * (longint'(1) << oss)) + 2) / 4;
    x1 = w32(ac3 * b6) / 8192;
    x2 = w32(b1 * sq) / 65536;
    x3 = w32(w32(x1 + x2) + 2) / 4;
    b4 = ((u64_t'(ac4) * (u64_t'(w32(x3 + 32768)) & 64'hFFFFFFFF))
          & 64'hFFFFFFFF) / 32768;
    b7 = ((u64_t'(up - b3) & 64'hFFFFFFFF) * (50000 >> oss)) & 64'hFFFFFFFF;
    if (b4 == 0) begin
      r.div_error = 1'b1;
      r.press_pa = 17'h1FFFF;
    end else begin
      if (b7 < 64'h80000000) pu = ((b7 * 2) & 64'hFFFFFFFF) / b4;
      else pu = ((b7 / b4) * 2) & 64'hFFFFFFFF;
      p = w32(longint'(pu));
      x1 = w32((p / 256) * (p / 256));
      x1 = w32(x1 * 3038) / 65536;
      x2 = w32(-7357 * p) / 65536;
      p = w32(p + w32(w32(x1 + x2) + 3791) / 16);
      if (p < 0) p = 0;
      else if (p > 131071) p = 131071;
      r.press_pa = p[16:0];
    end
    return r;
  endfunction

  // Result checker and random back-pressure.
  initial begin
    int stall;
    comp_result_t exp_r;
    out_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if ($signed(out_tdata[10:0]) !== exp_r.temp_tenths) begin
            $error("temp_tenths expected %0d actual %0d", exp_r.temp_tenths,
                   $signed(out_tdata[10:0]));
            errors++;
          end
          if (out_tdata[27:11] !== exp_r.press_pa) begin
            $error("press_pa expected %0d actual %0d", exp_r.press_pa, out_tdata[27:11]);
            errors++;
          end
          if (out_tuser !== exp_r.div_error) begin
            $error("div_error expected %0d actual %0d", exp_r.div_error, out_tuser);
            errors++;
          end
        end
        stall = sink_stall_en ? int'($urandom_range(0, 6)) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_reading(logic [15:0] raw_t, logic [23:0] raw_p, bit gaps = 1);
    int gap;
    gap = gaps ? int'($urandom_range(0, 6)) : 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {raw_p, raw_t};
    pending_results.push_back(compensate(raw_t, raw_p));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_CAL0: cal0 = val;
      REG_CAL1: cal1 = val;
      REG_CAL2: cal2 = {16'd0, val[47:0]};
      default:  oss = val[1:0];
    endcase
  endtask

  task automatic load_datasheet_cal(logic [1:0] mode);
    write_reg(REG_CAL0, {16'd32741, -16'sd14383, -16'sd72, 16'sd408});
    write_reg(REG_CAL1, {16'sd4, 16'sd6190, 16'd23153, 16'd32757});
    write_reg(REG_CAL2, {16'd0, 16'sd2868, -16'sd8711, -16'sd32768});
    write_reg(REG_OSS, {62'd0, mode});
  endtask

  task automatic test_reset_defaults();
    send_reading(16'h0000, 24'h000000, 0);
    send_reading(16'hFFFF, 24'hFFFFFF, 0);
    drain();
  endtask

  task automatic test_directed();
    load_datasheet_cal(2'd0);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'h0000, 24'h000000);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'h8000, 24'h800000);
    drain();
    // Temperature divisor zero: MD equal to minus X1 with AC5 zero.
    write_reg(REG_CAL1, {16'sd4, 16'sd6190, 16'd23153, 16'd0});
    write_reg(REG_CAL2, {16'd0, 16'sd0, -16'sd8711, -16'sd32768});
    send_reading(16'd1234, 24'h123456);
    send_reading(16'hFFFF, 24'hFFFFFF);
    drain();
    // Pressure divisor zero: AC4 zero.
    load_datasheet_cal(2'd3);
    write_reg(REG_CAL0, {16'd0, -16'sd14383, -16'sd72, 16'sd408});
    send_reading(16'd27898, 24'h5D2300);
    send_reading(16'h7FFF, 24'h000001);
    drain();
    // Extreme calibration words to force wrapping arithmetic.
    write_reg(REG_CAL0, 64'h7FFF_8000_7FFF_FFFF);
    write_reg(REG_CAL1, 64'h8000_7FFF_FFFF_FFFF);
    write_reg(REG_CAL2, 64'h0000_0001_7FFF_0000);
    write_reg(REG_OSS, 64'd2);
    send_reading(16'h0000, 24'hFFFFFF);
    send_reading(16'hFFFF, 24'h000000);
    drain();
    write_reg(REG_OSS, 64'd1);
    send_reading(16'h5555, 24'hAAAAAA);
    send_reading(16'hAAAA, 24'h555555);
    drain();
  endtask

  task automatic test_random_readings();
    int phase;
    for (phase = 0; phase < 10; phase++) begin
      if (phase % 3 == 0) begin
        load_datasheet_cal(phase[1:0]);
      end else begin
        write_reg(REG_CAL0, {$urandom, $urandom});
        write_reg(REG_CAL1, {$urandom, $urandom});
        write_reg(REG_CAL2, {$urandom, $urandom});
        write_reg(REG_OSS, {$urandom, $urandom});
      end
      sink_stall_en = (phase % 4 != 1);
      repeat (125) begin
        if ($urandom_range(0, 3) != 0)
          send_reading(16'($urandom_range(20000, 36000)),
                       24'($urandom_range(0, 24'hFFFFFF)), phase != 5);
        else
          send_reading(16'($urandom), 24'($urandom), phase != 5);
      end
      // Hold off until every outstanding result has returned.
      drain();
    end
  endtask

  initial begin
    errors = 0;
    sink_stall_en = 1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal0 = '0; cal1 = '0; cal2 = '0; oss = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_readings();
    if (errors == 0) begin
      $display("barometric_pressure_compensation test passed");
    end else begin
      $display("barometric_pressure_compensation test failed");
    end
    $finish;
  end
endmodule
